// File: rtl/drsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the demo record stream deframer.
package drsd_pkg;

    localparam int unsigned FILE_LEN_W     = 20;
    localparam int unsigned WPOS_W         = 18;
    localparam int unsigned CNT_W          = 18;
    localparam int unsigned RECS_W         = 10;
    localparam int unsigned CPF_W          = 3;

    localparam logic [31:0] MAX_FILE_BYTES = 32'd1048576;
    localparam logic [31:0] HDR_BYTES      = 32'd232;
    localparam logic [31:0] PAD_ROUND      = 32'd15;
    localparam logic [31:0] CPF_MAX        = 32'd4;

    localparam logic [WPOS_W-1:0] HDR_LAST_WORD = WPOS_W'(232 / 4 - 1);
    localparam logic [WPOS_W-1:0] W_STAGE       = WPOS_W'(16 / 4);
    localparam logic [WPOS_W-1:0] W_CMDS        = WPOS_W'(24 / 4);
    localparam logic [WPOS_W-1:0] W_STORED      = WPOS_W'(128 / 4);

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_BLOCK   = 3'd1,
        KIND_RECORD  = 3'd2,
        KIND_END     = 3'd3,
        KIND_REJECT  = 3'd4,
        KIND_IGNORED = 3'd5
    } kind_t;

    typedef struct packed {
        logic [31:0] file_word;
        logic [7:0]  our_seed_byte;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [7:0]  stick_x;
        logic signed [7:0]  stick_y;
        logic [15:0]        pad_word;
        logic               seed_match;
        logic [31:0]        stage_number;
        logic [CNT_W-1:0]   blocks_seen;
        logic [CNT_W-1:0]   frames_seen;
        logic [CNT_W-1:0]   agree_total;
        logic [CNT_W-1:0]   checked_total;
        logic [CNT_W-1:0]   first_mismatch_block;
        logic               first_mismatch_valid;
    } result_t;

endpackage

// File: rtl/demo_record_stream_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the demo record stream deframer.
// Pipeline: an accepted beat passes two register stages, the input register and then
//   the result register, before its result shows at out_valid.
// Throughput: one word per cycle unless the output stalls; parsing is combinational.
// Reset: rst_n is asynchronous and active low; it clears both stages, file_length,
//   the parse state and every counter. No clearing pass is needed.
module demo_record_stream_deframer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [drsd_pkg::FILE_LEN_W-1:0] cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     file_word,
    input  logic [7:0]                      our_seed_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      kind,
    output logic signed [7:0]               stick_x,
    output logic signed [7:0]               stick_y,
    output logic [15:0]                     pad_word,
    output logic                            seed_match,
    output logic [31:0]                     stage_number,
    output logic [drsd_pkg::CNT_W-1:0]      blocks_seen,
    output logic [drsd_pkg::CNT_W-1:0]      frames_seen,
    output logic [drsd_pkg::CNT_W-1:0]      agree_total,
    output logic [drsd_pkg::CNT_W-1:0]      checked_total,
    output logic [drsd_pkg::CNT_W-1:0]      first_mismatch_block,
    output logic                            first_mismatch_valid
);
    import drsd_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    fire;
    result_t step_res;
    result_t out_res;

    // Pack the input fields into one beat.
    assign in_item.file_word     = file_word;
    assign in_item.our_seed_byte = our_seed_byte;

    // The held word is parsed in the cycle the result register can take it;
    // parse state advances only then, so a stall on the output freezes everything.
    assign fire = held_valid && advance;

    drsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (held_valid),
        .item       (held_item)
    );

    drsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (held_item),
        .res         (step_res)
    );

    drsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (held_valid),
        .res_in    (step_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .advance   (advance),
        .res_out   (out_res)
    );

    // Unpack the result beat onto the field ports.
    assign kind                 = out_res.kind;
    assign stick_x              = out_res.stick_x;
    assign stick_y              = out_res.stick_y;
    assign pad_word             = out_res.pad_word;
    assign seed_match           = out_res.seed_match;
    assign stage_number         = out_res.stage_number;
    assign blocks_seen          = out_res.blocks_seen;
    assign frames_seen          = out_res.frames_seen;
    assign agree_total          = out_res.agree_total;
    assign checked_total        = out_res.checked_total;
    assign first_mismatch_block = out_res.first_mismatch_block;
    assign first_mismatch_valid = out_res.first_mismatch_valid;

endmodule

// File: rtl/drsd_in_stage.sv
`timescale 1ns / 1ps
// Input register: holds one accepted beat until the parser consumes it.
module drsd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  drsd_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output drsd_pkg::item_t item
);
    import drsd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held beat leaves this cycle.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: rtl/drsd_parser.sv
`timescale 1ns / 1ps
// Parse state, counters and the single-word step that forms each result.
module drsd_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [drsd_pkg::FILE_LEN_W-1:0] cfg_wr_data,
    input  logic                            fire,
    input  drsd_pkg::item_t                 item,
    output drsd_pkg::result_t               res
);
    import drsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BLOCK,
        PH_RECORD,
        PH_DONE,
        PH_REJECT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [FILE_LEN_W-1:0] flen_reg;
    logic [WPOS_W-1:0]  wpos_reg, wpos_next;
    logic [RECS_W-1:0]  recs_left_reg, recs_left_next;
    logic [CPF_W-1:0]   cpf_reg, cpf_next;
    logic [31:0]        stored_reg, stored_next;
    logic [31:0]        stage_reg, stage_next;
    logic [CNT_W-1:0]   block_cnt_reg, block_cnt_next;
    logic [CNT_W-1:0]   frame_cnt_reg, frame_cnt_next;
    logic [CNT_W-1:0]   agree_cnt_reg, agree_cnt_next;
    logic [CNT_W-1:0]   check_cnt_reg, check_cnt_next;
    logic [CNT_W-1:0]   mis_idx_reg, mis_idx_next;
    logic               mis_seen_reg, mis_seen_next;

    logic [31:0]        w;
    logic [31:0]        flen32;
    logic [31:0]        padded;
    logic [7:0]         speed, count, seed;
    logic [RECS_W-1:0]  recs;
    logic [FILE_LEN_W:0] hdr_end;
    logic [FILE_LEN_W:0] blk_end;
    logic               len_bad;

    assign w      = item.file_word;
    assign flen32 = 32'(flen_reg);
    assign speed  = w[31:24];
    assign count  = w[23:16];
    assign seed   = w[15:8];
    assign recs   = RECS_W'(cpf_reg) * RECS_W'(count);
    assign hdr_end = {1'b0, wpos_reg, 2'b00} + (FILE_LEN_W + 1)'(4);
    assign blk_end = hdr_end + (FILE_LEN_W + 1)'({recs, 2'b00});
    assign len_bad = (flen32 <= HDR_BYTES) || (flen32 > MAX_FILE_BYTES);
    // Stored length as it stands after this header word, rounded up to 16.
    assign padded  = (((wpos_reg == W_STORED) ? w : stored_reg) + PAD_ROUND) & ~PAD_ROUND;

    always_comb
    begin
        phase_next     = phase_reg;
        wpos_next      = wpos_reg;
        recs_left_next = recs_left_reg;
        cpf_next       = cpf_reg;
        stored_next    = stored_reg;
        stage_next     = stage_reg;
        block_cnt_next = block_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        agree_cnt_next = agree_cnt_reg;
        check_cnt_next = check_cnt_reg;
        mis_idx_next   = mis_idx_reg;
        mis_seen_next  = mis_seen_reg;

        res.kind       = KIND_IGNORED;
        res.stick_x    = '0;
        res.stick_y    = '0;
        res.pad_word   = '0;
        res.seed_match = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (len_bad)
                begin
                    phase_next = PH_REJECT;
                    res.kind   = KIND_REJECT;
                end
                else
                begin
                    res.kind = KIND_HEADER;
                    if (wpos_reg == W_STAGE)
                    begin
                        stage_next = w;
                    end
                    if (wpos_reg == W_CMDS)
                    begin
                        cpf_next = (w >= 32'd1 && w <= CPF_MAX) ? w[CPF_W-1:0] : '0;
                    end
                    if (wpos_reg == W_STORED)
                    begin
                        stored_next = w;
                    end
                    wpos_next = wpos_reg + 1'b1;
                    if (wpos_reg >= HDR_LAST_WORD)
                    begin
                        if (padded != flen32 || cpf_next == '0)
                        begin
                            phase_next = PH_REJECT;
                            res.kind   = KIND_REJECT;
                        end
                        else
                        begin
                            phase_next = PH_BLOCK;
                        end
                    end
                end
            end
            PH_BLOCK:
            begin
                if (hdr_end > {1'b0, flen_reg} || (count == '0 && speed == '0)
                    || blk_end > {1'b0, flen_reg})
                begin
                    phase_next = PH_DONE;
                    res.kind   = KIND_END;
                end
                else
                begin
                    res.kind       = KIND_BLOCK;
                    check_cnt_next = check_cnt_reg + 1'b1;
                    if (seed == item.our_seed_byte)
                    begin
                        agree_cnt_next = agree_cnt_reg + 1'b1;
                        res.seed_match = 1'b1;
                    end
                    else if (!mis_seen_reg)
                    begin
                        mis_seen_next = 1'b1;
                        mis_idx_next  = block_cnt_reg;
                    end
                    block_cnt_next = block_cnt_reg + 1'b1;
                    recs_left_next = recs;
                    phase_next     = (recs != '0) ? PH_RECORD : PH_BLOCK;
                    wpos_next      = wpos_reg + 1'b1;
                end
            end
            PH_RECORD:
            begin
                res.kind       = KIND_RECORD;
                res.stick_x    = w[31:24];
                res.stick_y    = w[23:16];
                res.pad_word   = {w[7:0], w[15:8]};
                frame_cnt_next = frame_cnt_reg + 1'b1;
                wpos_next      = wpos_reg + 1'b1;
                if (recs_left_reg != '0)
                begin
                    recs_left_next = recs_left_reg - 1'b1;
                end
                if (recs_left_next == '0)
                begin
                    phase_next = PH_BLOCK;
                end
            end
            PH_DONE, PH_REJECT:
            begin
                res.kind = KIND_IGNORED;
            end
            default:
            begin
                res.kind = KIND_IGNORED;
            end
        endcase

        res.stage_number         = stage_next;
        res.blocks_seen          = block_cnt_next;
        res.frames_seen          = frame_cnt_next;
        res.agree_total          = agree_cnt_next;
        res.checked_total        = check_cnt_next;
        res.first_mismatch_block = mis_idx_next;
        res.first_mismatch_valid = mis_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            flen_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            wpos_reg      <= '0;
            recs_left_reg <= '0;
            cpf_reg       <= '0;
            stored_reg    <= '0;
            stage_reg     <= '0;
            block_cnt_reg <= '0;
            frame_cnt_reg <= '0;
            agree_cnt_reg <= '0;
            check_cnt_reg <= '0;
            mis_idx_reg   <= '0;
            mis_seen_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            wpos_reg      <= wpos_next;
            recs_left_reg <= recs_left_next;
            cpf_reg       <= cpf_next;
            stored_reg    <= stored_next;
            stage_reg     <= stage_next;
            block_cnt_reg <= block_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            agree_cnt_reg <= agree_cnt_next;
            check_cnt_reg <= check_cnt_next;
            mis_idx_reg   <= mis_idx_next;
            mis_seen_reg  <= mis_seen_next;
        end
    end

endmodule

// File: rtl/drsd_out_stage.sv
`timescale 1ns / 1ps
// Result register: holds one result beat until the consumer takes it.
module drsd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  drsd_pkg::result_t res_in,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              advance,
    output drsd_pkg::result_t res_out
);
    import drsd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Open to a new result when empty or when the held one is taken now.
    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= load;
            if (load)
            begin
                res_reg <= res_in;
            end
        end
    end

endmodule

// File: rtl/drsd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the deframer top level, with its bind.
module drsd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [2:0]                 kind,
    input logic signed [7:0]          stick_x,
    input logic [15:0]                pad_word,
    input logic                       seed_match,
    input logic                       first_mismatch_valid
);
    import drsd_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pad_word))
        else $error("result beat changed while stalled");

    // Never stall the input while the result register is empty.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result register");

    // Drop record fields on non-record results, and seed match on non-block results.
    a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RECORD |-> stick_x == 8'sd0 && pad_word == 16'd0)
        else $error("record fields set on a non-record beat");

    a_match_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seed_match |-> kind == KIND_BLOCK)
        else $error("seed match on a non-block beat");

    // Once a mismatch is flagged, it stays flagged until reset.
    a_mismatch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        first_mismatch_valid |=> first_mismatch_valid)
        else $error("mismatch flag cleared");

endmodule

bind demo_record_stream_deframer_top drsd_checker u_drsd_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_ready             (in_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .kind                 (kind),
    .stick_x              (stick_x),
    .pad_word             (pad_word),
    .seed_match           (seed_match),
    .first_mismatch_valid (first_mismatch_valid)
);
